>>> rtl/pixel_gamma_correct_unit_macros.svh
// Assertion macros for the pixel gamma correction unit.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PIXEL_GAMMA_CORRECT_UNIT_MACROS_SVH
`define PIXEL_GAMMA_CORRECT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PGC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define PGC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PGC_ASSERT(lbl, clk, rst, prop)
`define PGC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/pgc_pkg.sv
// Package for the pixel gamma correction unit: item types, pipeline stage types,
// constants and the elaboration-time log and root tables. No dependencies.
package pgc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_W     = 19;
  localparam int EXP_W     = 23;
  localparam int NCHAN     = 3;
  localparam int STEPS     = FRAC_BITS;
  localparam int NSTAGE    = STEPS + 3;

  localparam logic [15:0] GAMMA_RESET = 16'd4096;

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_FULL
  } pgc_special_t;

  typedef struct packed {
    pgc_special_t         code;
    logic                 one;
    logic [31:0]          r;
    logic [2:0]           n;
    logic [FRAC_BITS-1:0] frac;
  } pgc_lane_t;

  typedef struct packed {
    pgc_lane_t [NCHAN-1:0] lane;
    logic [7:0]            alpha;
    logic                  last;
  } pgc_stage_t;

  typedef struct packed {
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] alpha_in;
    logic       last_in;
  } pgc_in_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } pgc_out_t;

  typedef logic [LOG_W-1:0] pgc_dtab_t [256];

  function automatic logic [LOG_W-1:0] pgc_log2_q16(input int unsigned x);
    int unsigned e;
    logic [63:0] m;
    logic [FRAC_BITS-1:0] frac;
    e = 0;
    while (e < 7 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (30 - e);
    frac = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = {frac[FRAC_BITS-2:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {e[2:0], frac};
  endfunction

  function automatic pgc_dtab_t pgc_build_dtab();
    pgc_dtab_t t;
    logic [LOG_W-1:0] top;
    top = pgc_log2_q16(255);
    t[0] = '0;
    for (int c = 1; c < 256; c++) begin
      t[c] = top - pgc_log2_q16(c);
    end
    return t;
  endfunction

  localparam pgc_dtab_t DTAB = pgc_build_dtab();

  function automatic logic [31:0] pgc_isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // Factor 2^(-2^-k) in Q0.32, by k successive square roots from one half.
  function automatic logic [31:0] pgc_root(input int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      t = {32'd0, pgc_isqrt64(t << 32)};
    end
    return t[31:0];
  endfunction

endpackage

>>> rtl/pgc_front.sv
// Front stages of the gamma pipeline: log ratio table lookup, then the product
// with the gamma register. Depends on pgc_pkg.
module pgc_front import pgc_pkg::*; (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  pgc_in_t     in_item,
  input  logic [15:0] gamma,
  output pgc_stage_t  stage_b
);

  logic [NCHAN-1:0][7:0]       ch;
  logic [NCHAN-1:0][LOG_W-1:0] d_next;
  pgc_special_t                code_next [NCHAN];
  logic [NCHAN-1:0][LOG_W-1:0] d;
  pgc_special_t                code [NCHAN];
  logic [7:0]                  alpha;
  logic                        last;
  logic [LOG_W+15:0]           prod [NCHAN];
  logic [EXP_W-1:0]            e [NCHAN];
  pgc_stage_t                  stage_b_next;

  assign ch = {in_item.chan2_in, in_item.chan1_in, in_item.chan0_in};

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      d_next[i] = DTAB[ch[i]];
      if (gamma == '0) begin
        code_next[i] = SP_FULL;
      end else if (ch[i] == 8'd0) begin
        code_next[i] = SP_ZERO;
      end else if (ch[i] == 8'd255) begin
        code_next[i] = SP_FULL;
      end else begin
        code_next[i] = SP_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      d     <= d_next;
      code  <= code_next;
      alpha <= in_item.alpha_in;
      last  <= in_item.last_in;
    end
  end

  always_comb begin
    stage_b_next.alpha = alpha;
    stage_b_next.last  = last;
    for (int i = 0; i < NCHAN; i++) begin
      prod[i] = (LOG_W+16)'(d[i]) * (LOG_W+16)'(gamma);
      e[i]    = prod[i][LOG_W+15:12];
      if (code[i] == SP_NONE && e[i][EXP_W-1:FRAC_BITS+3] != '0) begin
        stage_b_next.lane[i].code = SP_ZERO;
      end else begin
        stage_b_next.lane[i].code = code[i];
      end
      stage_b_next.lane[i].one  = 1'b1;
      stage_b_next.lane[i].r    = '0;
      stage_b_next.lane[i].n    = e[i][FRAC_BITS+2:FRAC_BITS];
      stage_b_next.lane[i].frac = e[i][FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      stage_b <= stage_b_next;
    end
  end

endmodule

>>> rtl/pgc_exp_step.sv
// One stage of the fractional power of two: multiplies by one root factor when
// its exponent bit is set, for all three colour lanes. Depends on pgc_pkg.
module pgc_exp_step import pgc_pkg::*; #(
  parameter int K = 1
) (
  input  logic       clk,
  input  logic       en,
  input  pgc_stage_t d_in,
  output pgc_stage_t d_out
);

  localparam logic [31:0] ROOT = pgc_root(K);
  localparam int          BITPOS = FRAC_BITS - K;

  logic [63:0] prod [NCHAN];
  pgc_stage_t  d_next;

  always_comb begin
    d_next = d_in;
    for (int i = 0; i < NCHAN; i++) begin
      prod[i] = 64'(d_in.lane[i].r) * 64'(ROOT);
      if (d_in.lane[i].frac[BITPOS]) begin
        d_next.lane[i].one = 1'b0;
        if (d_in.lane[i].one) begin
          d_next.lane[i].r = ROOT;
        end else begin
          d_next.lane[i].r = prod[i][63:32];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

>>> rtl/pgc_back.sv
// Output stage of the gamma pipeline: scales the power by 255, applies the
// integer shift and the special cases, and holds the result item. Depends on pgc_pkg.
module pgc_back import pgc_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  pgc_stage_t d_in,
  output pgc_out_t   d_out
);

  logic [39:0]           prod [NCHAN];
  logic [7:0]            base [NCHAN];
  logic [NCHAN-1:0][7:0] y;
  pgc_out_t              d_next;

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      prod[i] = 40'(d_in.lane[i].r) * 40'd255;
      base[i] = d_in.lane[i].one ? 8'hFF : prod[i][39:32];
      case (d_in.lane[i].code)
        SP_ZERO: y[i] = 8'd0;
        SP_FULL: y[i] = 8'hFF;
        default: y[i] = base[i] >> d_in.lane[i].n;
      endcase
    end
    d_next.chan0_out = y[0];
    d_next.chan1_out = y[1];
    d_next.chan2_out = y[2];
    d_next.alpha_out = d_in.alpha;
    d_next.last_out  = d_in.last;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

>>> rtl/pixel_gamma_correct_unit.sv
// Gamma correction of one 8-bit RGBA pixel per item: the three colour bytes are
// raised to the power held in the Q4.12 gamma register, alpha and last are copied.
// The unit takes one pixel every clock cycle while the output is not stalled; its
// pipeline holds the sixteen root multiplications of the fractional power of
// two, one stage each, between a table lookup, the gamma product and the output
// stage. A stalled output holds its item while empty stages further up still fill.
// Write the gamma register only while no pixel is in flight.
module pixel_gamma_correct_unit import pgc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  pgc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pgc_out_t    out_data
);

  `include "pixel_gamma_correct_unit_macros.svh"

  logic [15:0]       gamma;
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;
  pgc_stage_t        st [STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gamma <= cfg_data;
    end
  end

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];

  pgc_front u_front (
    .clk     (clk),
    .en_a    (en[0]),
    .en_b    (en[1]),
    .in_item (in_data),
    .gamma   (gamma),
    .stage_b (st[0])
  );

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    pgc_exp_step #(
      .K (j + 1)
    ) u_step (
      .clk   (clk),
      .en    (en[j+2]),
      .d_in  (st[j]),
      .d_out (st[j+1])
    );
  end

  pgc_back u_back (
    .clk   (clk),
    .en    (en[NSTAGE-1]),
    .d_in  (st[STEPS]),
    .d_out (out_data)
  );

  `PGC_ASSERT(a_stall_only_from_output, clk, rst, !in_ready |-> (out_valid && !out_ready))
  `PGC_ASSERT_ALWAYS(a_empty_after_reset, clk, (rst ##1 1'b1) |-> (v == '0))
  `PGC_ASSERT(a_gamma_zero_full, clk, rst, (out_valid && gamma == '0) |-> (out_data.chan0_out == 8'hFF && out_data.chan1_out == 8'hFF && out_data.chan2_out == 8'hFF))

endmodule

>>> tb/testbench.sv
// Self-checking testbench for pixel_gamma_correct_unit: drives RGBA pixels and gamma
// writes through valid/ready with random gaps and stalls, predicts each corrected pixel.
// Depends on pixel_gamma_correct_unit, and on pgc_pkg for the payload types and the gamma reset value.
module testbench;
  import pgc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SETTINGS = 12;
  localparam int RANDOM_PER_SETTING = 46;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pgc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pgc_out_t out_data;

  pgc_in_t pending_pixels[$];
  pgc_out_t corrected_q[$];
  bit [15:0] gamma_shadow = GAMMA_RESET;
  bit in_fire;
  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned pixels_returned;
  int unsigned gamma_writes;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned hold_left;
  bit send_burst;
  bit take_burst;

  pixel_gamma_correct_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial forever #10 clk = ~clk;

  function automatic bit [18:0] byte_log2(int unsigned x);
    int unsigned ip;
    bit [63:0] m;
    bit [15:0] fr;
    ip = 0;
    while (ip < 7 && (x >> (ip + 1)) != 0) ip++;
    m = 64'(x) << (30 - ip);
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = {fr[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {ip[2:0], fr};
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] rem;
    bit [63:0] res;
    bit [63:0] b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(-f/65536) in Q0.32, one truncated root factor per set fraction bit.
  function automatic bit [63:0] neg_frac_exp2(bit [15:0] f);
    bit [63:0] acc;
    bit [63:0] root;
    acc = 64'd1 << 32;
    root = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      root = int_sqrt(root << 32);
      if (f[16-k]) acc = (acc * root) >> 32;
    end
    return acc;
  endfunction

  function automatic bit [7:0] gamma_map(bit [7:0] c, bit [15:0] g);
    bit [18:0] d;
    bit [63:0] e;
    bit [63:0] n;
    bit [63:0] r;
    bit [63:0] y;
    if (g == 16'd0) return 8'd255;
    if (c == 8'd0) return 8'd0;
    if (c == 8'd255) return 8'd255;
    d = byte_log2(255) - byte_log2(c);
    e = (64'(d) * 64'(g)) >> 12;
    n = e >> 16;
    if (n >= 32) return 8'd0;
    r = neg_frac_exp2(e[15:0]);
    y = (64'd255 * r) >> (32 + n);
    if (y > 255) y = 255;
    return y[7:0];
  endfunction

  function automatic pgc_out_t gamma_correct_pixel(pgc_in_t p, bit [15:0] g);
    pgc_out_t o;
    o.chan0_out = gamma_map(p.chan0_in, g);
    o.chan1_out = gamma_map(p.chan1_in, g);
    o.chan2_out = gamma_map(p.chan2_in, g);
    o.alpha_out = p.alpha_in;
    o.last_out = p.last_in;
    return o;
  endfunction

  function automatic pgc_in_t make_pixel(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2,
                                         bit [7:0] a, bit l);
    pgc_in_t p;
    p.chan0_in = c0;
    p.chan1_in = c1;
    p.chan2_in = c2;
    p.alpha_in = a;
    p.last_in = l;
    return p;
  endfunction

  function automatic bit [7:0] random_channel();
    bit [7:0] corners[5];
    corners = '{8'd0, 8'd1, 8'd2, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s of pixel %0d: expected %0d, got %0d",
               field, pixels_returned, want, got);
  endtask

  always @(posedge clk) begin
    pgc_out_t want;
    if (rst) begin
      in_fire = 1'b0;
      gamma_shadow = GAMMA_RESET;
    end else begin
      in_fire = in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        gamma_shadow = cfg_data;
        gamma_writes++;
      end
      if (in_fire) begin
        corrected_q.push_back(gamma_correct_pixel(in_data, gamma_shadow));
        pixels_taken++;
      end
      if (out_valid && out_ready) begin
        if (corrected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("pixel returned with none outstanding: %h", out_data);
        end else begin
          want = corrected_q.pop_front();
          if (out_data.chan0_out !== want.chan0_out)
            note_mismatch("chan0", want.chan0_out, out_data.chan0_out);
          if (out_data.chan1_out !== want.chan1_out)
            note_mismatch("chan1", want.chan1_out, out_data.chan1_out);
          if (out_data.chan2_out !== want.chan2_out)
            note_mismatch("chan2", want.chan2_out, out_data.chan2_out);
          if (out_data.alpha_out !== want.alpha_out)
            note_mismatch("alpha", want.alpha_out, out_data.alpha_out);
          if (out_data.last_out !== want.last_out)
            note_mismatch("last", want.last_out, out_data.last_out);
        end
        pixels_returned++;
      end
      if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("no item moved for %0d cycles", QUIET_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    pgc_in_t next_pixel;
    logic next_valid;
    if (!rst) begin
      next_valid = in_valid && !in_fire;
      next_pixel = in_data;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pixels.size() > 0) begin
          next_pixel = pending_pixels.pop_front();
          next_valid = 1'b1;
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : pick_gap();
        end
      end
      in_valid <= next_valid;
      in_data <= next_pixel;
    end
  end

  always @(negedge clk) begin
    logic next_ready;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if ($urandom_range(0, 49) == 0) take_burst = !take_burst;
        if (!take_burst && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
      out_ready <= next_ready;
    end
  end

  task automatic write_gamma(bit [15:0] g);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (!(pixels_taken == pixels_queued && pixels_returned == pixels_taken));
  endtask

  task automatic queue_pixel(pgc_in_t p);
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  initial begin
    bit [15:0] gamma_plan[N_SETTINGS];
    gamma_plan = '{GAMMA_RESET, 16'd0, 16'd65535, 16'd1, 16'd2, 16'd9011, 16'd1862,
                   16'd4095, 16'd4097, 16'd32768, 16'd0, 16'd0};
    gamma_plan[10] = 16'($urandom_range(1229, 12288));
    gamma_plan[11] = 16'($urandom_range(1, 65535));
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    for (int s = 0; s < N_SETTINGS; s++) begin
      // The first setting runs on the reset value of the gamma register.
      if (s > 0) write_gamma(gamma_plan[s]);
      @(posedge clk);
      queue_pixel(make_pixel(8'd0, 8'd255, 8'd1, 8'h00, 1'b0));
      queue_pixel(make_pixel(8'd254, 8'd128, 8'd127, 8'hFF, 1'b1));
      if (s == 0) begin
        queue_pixel(make_pixel(8'd2, 8'd64, 8'd200, 8'h5A, 1'b0));
        queue_pixel(make_pixel(8'd253, 8'd16, 8'd32, 8'hA5, 1'b1));
      end
      for (int i = 0; i < RANDOM_PER_SETTING; i++)
        queue_pixel(make_pixel(random_channel(), random_channel(), random_channel(),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (corrected_q.size() != 0) begin
      $display("%0d corrected pixels never returned", corrected_q.size());
      mismatches += corrected_q.size();
    end
    $display("run covered %0d pixels over %0d gamma settings (%0d register writes)",
             pixels_returned, N_SETTINGS, gamma_writes);
    $display("%0d mismatches found", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
